/* rtl/fsif_pkg.sv */
package fsif_pkg;

    // Argument width default and register file layout
    localparam int          P_ARG_BITS  = 32;
    localparam int          P_ADDR_W    = 3;
    localparam logic [15:0] P_CAP_RESET = 16'd256;

    // Register index, taken from paddr[P_ADDR_W-1:2]
    localparam logic [P_ADDR_W-3:0] REG_CAPACITY = '0;

    // Input opcodes
    localparam logic [1:0] OP_FMT = 2'd0;
    localparam logic [1:0] OP_STR = 2'd1;
    localparam logic [1:0] OP_END = 2'd2;

    // Number bases of the converter
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_BIN = 2'd2;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_S     = 8'h73;

    // Converter control and status
    typedef struct packed {
        logic       start;
        logic       take;
        logic       stop;
        logic [1:0] base;
    } t_conv_ctl;

    typedef struct packed {
        logic busy;
        logic valid;
        logic last;
    } t_conv_sts;

    // ASCII for one digit value 0..15, lower-case hex
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d <= 4'd9) begin
            c = 8'(CH_ZERO + {4'b0, d});
        end else begin
            c = 8'(CH_LA + {4'b0, d} - 8'd10);
        end
        return c;
    endfunction

endpackage

/* rtl/fsif_if.sv */
interface fsif_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  char_byte;
    logic [31:0] arg_value;

    modport source (output valid, output opcode, output char_byte, output arg_value,
                    input ready);
    modport sink   (input valid, input opcode, input char_byte, input arg_value,
                    output ready);
endinterface

interface fsif_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       status;

    modport source (output valid, output out_byte, output last, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input last, input status,
                    output ready);
endinterface

/* rtl/fsif_cfg.sv */
module fsif_cfg
    import fsif_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [P_ADDR_W-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output logic [15:0]         o_capacity
);

    logic [15:0] r_cap;
    logic        sel_cap;

    assign sel_cap = (paddr[P_ADDR_W-1:2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= P_CAP_RESET;
        end else if (psel && penable && pwrite && sel_cap) begin
            r_cap <= pwdata[15:0];
        end
    end

    assign prdata     = sel_cap ? {16'b0, r_cap} : '0;
    assign pready     = 1'b1;
    assign o_capacity = r_cap;

endmodule

/* rtl/fsif_conv.sv */
module fsif_conv
    import fsif_pkg::*;
#(
    parameter int ARG_BITS = P_ARG_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_conv_ctl           i_ctl,
    input  logic [ARG_BITS-1:0] i_value,
    output t_conv_sts           o_sts,
    output logic [7:0]          o_char
);

    localparam int NDIG  = (ARG_BITS * 30103) / 100000 + 1;
    localparam int NHEX  = (ARG_BITS + 3) / 4;
    localparam int SH_W  = 4 * NHEX;
    localparam int BCD_W = 4 * NDIG;
    localparam int CNT_W = $clog2(ARG_BITS + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DAB  = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;
    localparam logic [1:0] PH_EMIT = 2'd3;

    logic [1:0]       r_ph, n_ph;
    logic [1:0]       r_base, n_base;
    logic [CNT_W-1:0] r_left, n_left;
    logic [SH_W-1:0]  r_sh, n_sh;
    logic [BCD_W-1:0] r_bcd, n_bcd;

    logic [3:0]       cur_digit;
    logic [BCD_W-1:0] bcd_adj;
    logic             is_last;

    always_comb begin
        case (r_base)
            BASE_BIN: cur_digit = {3'b0, r_sh[SH_W-1]};
            BASE_HEX: cur_digit = r_sh[SH_W-1 -: 4];
            default:  cur_digit = r_bcd[BCD_W-1 -: 4];
        endcase
    end

    // Add 3 to every BCD digit of 5 or more before the next shift
    always_comb begin
        logic [3:0] dg;
        for (int k = 0; k < NDIG; k++) begin
            dg = r_bcd[4*k +: 4];
            bcd_adj[4*k +: 4] = (dg >= 4'd5) ? 4'(dg + 4'd3) : dg;
        end
    end

    assign is_last = (r_left == CNT_W'(1));

    always_comb begin
        n_ph   = r_ph;
        n_base = r_base;
        n_left = r_left;
        n_sh   = r_sh;
        n_bcd  = r_bcd;
        if (i_ctl.stop) begin
            n_ph = PH_IDLE;
        end else if (i_ctl.start) begin
            n_base = i_ctl.base;
            n_bcd  = '0;
            case (i_ctl.base)
                BASE_HEX: begin
                    n_sh   = SH_W'(i_value);
                    n_left = CNT_W'(NHEX);
                    n_ph   = PH_SKIP;
                end
                BASE_BIN: begin
                    n_sh   = SH_W'(i_value) << (SH_W - ARG_BITS);
                    n_left = CNT_W'(ARG_BITS);
                    n_ph   = PH_SKIP;
                end
                default: begin
                    n_sh   = SH_W'(i_value) << (SH_W - ARG_BITS);
                    n_left = CNT_W'(ARG_BITS);
                    n_ph   = PH_DAB;
                end
            endcase
        end else begin
            case (r_ph)
                PH_DAB: begin
                    n_bcd  = {bcd_adj[BCD_W-2:0], r_sh[SH_W-1]};
                    n_sh   = r_sh << 1;
                    n_left = r_left - CNT_W'(1);
                    if (is_last) begin
                        n_left = CNT_W'(NDIG);
                        n_ph   = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    // drop leading zeros, keep at least one digit
                    if (cur_digit == 4'd0 && !is_last) begin
                        n_left = r_left - CNT_W'(1);
                        case (r_base)
                            BASE_BIN: n_sh  = r_sh << 1;
                            BASE_HEX: n_sh  = r_sh << 4;
                            default:  n_bcd = r_bcd << 4;
                        endcase
                    end else begin
                        n_ph = PH_EMIT;
                    end
                end
                PH_EMIT: begin
                    if (i_ctl.take) begin
                        if (is_last) begin
                            n_ph = PH_IDLE;
                        end else begin
                            n_left = r_left - CNT_W'(1);
                            case (r_base)
                                BASE_BIN: n_sh  = r_sh << 1;
                                BASE_HEX: n_sh  = r_sh << 4;
                                default:  n_bcd = r_bcd << 4;
                            endcase
                        end
                    end
                end
                default: n_ph = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
        end else begin
            r_ph <= n_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_left <= n_left;
        r_sh   <= n_sh;
        r_bcd  <= n_bcd;
    end

    assign o_sts.busy  = (r_ph != PH_IDLE);
    assign o_sts.valid = (r_ph == PH_EMIT);
    assign o_sts.last  = is_last;
    assign o_char      = digit_char(cur_digit);

endmodule

/* rtl/format_string_integer_formatter.sv */
// Printf-style integer formatter. Each input word is a format character, a
// string byte or an end mark; each output word is one text byte with a last
// flag and a status bit, and the end mark yields a zero terminator carrying
// the message status (1 once an unknown specifier was seen). Literal text,
// %%, %c and string bytes load the output register directly. Numbers run
// through a shift-register converter. For %x and %b, leading-zero skipping
// and digit output together walk every digit position once (NHEX hex or
// ARG_BITS binary digits). %u / %d first run a bit-serial BCD conversion over
// the ARG_BITS argument bits, then the same walk over NDIG digits. NHEX =
// ceil(ARG_BITS/4) and NDIG is the decimal digit count of ARG_BITS bits.
// One item is worked at a time; the next is taken once the block is back in
// idle and the output register is empty or being drained. Output is at most
// one byte per cycle, and buffer_capacity (APB, offset 0) bounds the content
// bytes per message.
module format_string_integer_formatter
    import fsif_pkg::*;
#(
    parameter int ARG_BITS = P_ARG_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fsif_in_if.sink             i_item,
    fsif_out_if.source          o_res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [P_ADDR_W-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PRE  = 2'd1;
    localparam logic [1:0] S_DIG  = 2'd2;

    // Message state
    logic [1:0]  r_state, n_state;
    logic        r_pend, n_pend;
    logic        r_str, n_str;
    logic        r_failed, n_failed;
    logic [15:0] r_bw, n_bw;
    logic [7:0]  r_pre, n_pre;

    // Output register
    logic        r_ov, n_ov;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic        r_status, n_status;

    logic [15:0] cap;
    logic        out_free;
    logic        item_acc;
    logic        cap_hit;
    logic        room;

    logic [ARG_BITS-1:0] arg_v;
    logic [ARG_BITS-1:0] arg_mag;
    logic                arg_neg;

    t_conv_ctl   conv_ctl;
    t_conv_sts   conv_sts;
    logic [7:0]  conv_char;

    logic        ld;
    logic        ld_term;
    logic        ld_last;
    logic [7:0]  ld_byte;

    fsif_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (cap)
    );

    fsif_conv #(
        .ARG_BITS (ARG_BITS)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (conv_ctl),
        .i_value (arg_neg ? arg_mag : arg_v),
        .o_sts   (conv_sts),
        .o_char  (conv_char)
    );

    // Output register frees when empty or being drained this cycle
    assign out_free     = !r_ov || o_res.ready;
    assign i_item.ready = (r_state == S_IDLE) && out_free;
    assign item_acc     = i_item.valid && i_item.ready;

    // The next content byte fills the buffer
    assign cap_hit = (16'(r_bw + 16'd1) == cap);
    assign room    = (r_bw < cap);

    // Low ARG_BITS bits of the argument; %d takes the top one as the sign
    assign arg_v   = ARG_BITS'(i_item.arg_value);
    assign arg_mag = (~arg_v) + {{(ARG_BITS-1){1'b0}}, 1'b1};

    always_comb begin
        n_state  = r_state;
        n_pend   = r_pend;
        n_str    = r_str;
        n_failed = r_failed;
        n_bw     = r_bw;
        n_pre    = r_pre;
        n_ov     = r_ov && !o_res.ready;
        n_byte   = r_byte;
        n_last   = r_last;
        n_status = r_status;
        ld       = 1'b0;
        ld_term  = 1'b0;
        ld_last  = 1'b0;
        ld_byte  = CH_NUL;
        arg_neg  = 1'b0;
        conv_ctl = '0;
        conv_ctl.base = BASE_DEC;

        case (r_state)
            S_IDLE: begin
                if (item_acc) begin
                    if (i_item.opcode == OP_END) begin
                        // emit terminator, start a new message
                        ld       = 1'b1;
                        ld_term  = 1'b1;
                        n_pend   = 1'b0;
                        n_str    = 1'b0;
                        n_failed = 1'b0;
                    end else if ((i_item.opcode inside {OP_FMT, OP_STR}) && !r_failed
                                 && room) begin
                        if (i_item.opcode == OP_STR) begin
                            if (r_str) begin
                                if (i_item.char_byte == CH_NUL) begin
                                    n_str = 1'b0;
                                end else begin
                                    ld      = 1'b1;
                                    ld_byte = i_item.char_byte;
                                    ld_last = 1'b1;
                                end
                            end
                        end else begin
                            n_str = 1'b0;
                            if (i_item.char_byte != CH_NUL) begin
                                if (!r_pend) begin
                                    if (i_item.char_byte == CH_PCT) begin
                                        n_pend = 1'b1;
                                    end else begin
                                        ld      = 1'b1;
                                        ld_byte = i_item.char_byte;
                                        ld_last = 1'b1;
                                    end
                                end else begin
                                    n_pend = 1'b0;
                                    case (i_item.char_byte)
                                        CH_PCT: begin
                                            ld      = 1'b1;
                                            ld_byte = CH_PCT;
                                            ld_last = 1'b1;
                                        end
                                        CH_C: begin
                                            ld      = 1'b1;
                                            ld_byte = i_item.arg_value[7:0];
                                            ld_last = 1'b1;
                                        end
                                        CH_S: begin
                                            n_str = 1'b1;
                                        end
                                        CH_D, CH_U: begin
                                            arg_neg = (i_item.char_byte == CH_D)
                                                      && arg_v[ARG_BITS-1];
                                            if (arg_neg) begin
                                                ld      = 1'b1;
                                                ld_byte = CH_MINUS;
                                            end
                                            if (!(arg_neg && cap_hit)) begin
                                                conv_ctl.start = 1'b1;
                                                conv_ctl.base  = BASE_DEC;
                                                n_state        = S_DIG;
                                            end
                                        end
                                        CH_X, CH_B: begin
                                            ld      = 1'b1;
                                            ld_byte = CH_ZERO;
                                            if (!cap_hit) begin
                                                n_pre          = i_item.char_byte;
                                                conv_ctl.start = 1'b1;
                                                conv_ctl.base  =
                                                    (i_item.char_byte == CH_X) ? BASE_HEX
                                                                               : BASE_BIN;
                                                n_state        = S_PRE;
                                            end
                                        end
                                        default: begin
                                            // unknown specifier: fail, swallow the rest
                                            n_failed = 1'b1;
                                        end
                                    endcase
                                end
                            end
                        end
                    end
                end
            end
            S_PRE: begin
                // second prefix character while the converter works
                if (out_free) begin
                    ld      = 1'b1;
                    ld_byte = r_pre;
                    if (cap_hit) begin
                        conv_ctl.stop = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_DIG;
                    end
                end
            end
            S_DIG: begin
                if (conv_sts.valid && out_free) begin
                    ld            = 1'b1;
                    ld_byte       = conv_char;
                    ld_last       = conv_sts.last;
                    conv_ctl.take = 1'b1;
                    if (conv_sts.last || cap_hit) begin
                        conv_ctl.stop = cap_hit;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Load the output register; a content byte that fills the buffer ends the item
        if (ld) begin
            n_ov     = 1'b1;
            n_byte   = ld_byte;
            n_status = r_failed;
            if (ld_term) begin
                n_last = 1'b1;
                n_bw   = '0;
            end else begin
                n_last = ld_last || cap_hit;
                n_bw   = 16'(r_bw + 16'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_str    <= 1'b0;
            r_failed <= 1'b0;
            r_bw     <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_str    <= n_str;
            r_failed <= n_failed;
            r_bw     <= n_bw;
            r_ov     <= n_ov;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        r_pre    <= n_pre;
        r_byte   <= n_byte;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign o_res.valid    = r_ov;
    assign o_res.out_byte = r_byte;
    assign o_res.last     = r_last;
    assign o_res.status   = r_status;

    // A held word that is not the last one means the item is still in progress
    a_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_last |-> r_state != S_IDLE)
        else $error("non-last word held while idle");

    // %s clears pending percent, any format character clears string mode
    a_modes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && r_str))
        else $error("pending percent and string mode both set");

    // Draining digits requires a running converter
    a_conv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIG |-> conv_sts.busy)
        else $error("digit state without converter activity");

    // A failed message holds no word until its terminator clears the flag
    a_failed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> !r_ov && r_state == S_IDLE)
        else $error("output after failure");

endmodule

/* bench/tb_format_string_integer_formatter.sv */
`timescale 1ns / 1ps

module tb_format_string_integer_formatter;
    import fsif_pkg::*;

    // The fourth opcode carries no meaning; the block drops such words.
    localparam logic [1:0] OP_NONE = 2'd3;

    // Idle time after the last expected word before a register write or the
    // final verdict. It leaves ample margin over the slowest conversion (%d or
    // %u of a full word) without stalls.
    localparam int SETTLE_CYCLES = 120;

    // Cycles without any handshake before the run is declared hung. The
    // longest correct quiet stretch is the settle pause or one conversion
    // plus the longest sender gap and receiver stall, all well under this.
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       status;
    } t_text_word;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [P_ADDR_W-1:0] paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    fsif_in_if  item_bus ();
    fsif_out_if text_bus ();

    format_string_integer_formatter u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_bus),
        .o_res   (text_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Formatter state as the testbench sees it
    logic [15:0] cap_q;
    logic [15:0] written_q;
    logic        pct_q;
    logic        str_q;
    logic        bad_q;

    t_text_word expected_text[$];

    int  mismatches;
    int  words_checked;
    int  items_sent;
    int  caps_used;
    bit  quiet;          // suppress all idling on both sides

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Most gaps are zero or short; a few are long enough to span a whole
    // conversion.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Argument words lean toward the edges of the signed and unsigned range.
    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return 32'($urandom_range(0, 99));
            default: return 32'($urandom());
        endcase
    endfunction

    // Queue one content byte unless the message is already at capacity.
    function automatic void put_char(input logic [7:0] ch);
        if (written_q >= cap_q) return;
        expected_text.push_back('{out_byte: ch, last: 1'b0, status: bad_q});
        written_q = written_q + 16'd1;
    endfunction

    // Queue the digits of value, most significant first, without leading
    // zeros; zero itself gives a single '0'.
    function automatic void put_number(input logic [P_ARG_BITS-1:0] value,
                                       input int unsigned radix);
        logic [7:0]            digs [P_ARG_BITS];
        logic [P_ARG_BITS-1:0] v;
        int unsigned           r;
        int                    n;
        v = value;
        n = 0;
        if (v == '0) begin
            digs[0] = CH_ZERO;
            n = 1;
        end
        while (v != '0) begin
            r = int'(v % radix);
            v = v / radix;
            digs[n] = (r <= 9) ? 8'(CH_ZERO + r) : 8'(CH_LA + r - 10);
            n++;
        end
        for (int i = n - 1; i >= 0; i--) begin
            put_char(digs[i]);
        end
    endfunction

    // One format character: literal text, the start of a conversion, or the
    // specifier that completes one.
    function automatic void render_format(input logic [7:0] ch,
                                          input logic [P_ARG_BITS-1:0] arg);
        logic [P_ARG_BITS-1:0] v;
        v = arg;
        // A zero character is dropped and leaves a pending '%' pending.
        if (ch == CH_NUL) return;
        if (!pct_q) begin
            if (ch == CH_PCT) begin
                pct_q = 1'b1;
            end else begin
                put_char(ch);
            end
            return;
        end
        pct_q = 1'b0;
        case (ch)
            CH_PCT: put_char(CH_PCT);
            CH_D: begin
                if (v[P_ARG_BITS-1]) begin
                    put_char(CH_MINUS);
                    v = -v;
                end
                put_number(v, 10);
            end
            CH_U: put_number(v, 10);
            CH_C: put_char(v[7:0]);
            CH_S: str_q = 1'b1;
            CH_X: begin
                put_char(CH_ZERO);
                put_char(CH_X);
                put_number(v, 16);
            end
            CH_B: begin
                put_char(CH_ZERO);
                put_char(CH_B);
                put_number(v, 2);
            end
            // Unknown specifier: no output, and the rest of the message is
            // swallowed up to the end word.
            default: bad_q = 1'b1;
        endcase
    endfunction

    // Work out the text words that one accepted input word causes.
    function automatic void render_item(input logic [1:0] op, input logic [7:0] ch,
                                        input logic [31:0] arg);
        t_text_word tail;
        int         mark;
        mark = expected_text.size();
        if (op == OP_END) begin
            expected_text.push_back('{out_byte: CH_NUL, last: 1'b1, status: bad_q});
            pct_q     = 1'b0;
            str_q     = 1'b0;
            written_q = '0;
            bad_q     = 1'b0;
            return;
        end
        if (op == OP_NONE || bad_q || written_q >= cap_q) return;
        if (op == OP_STR) begin
            // String bytes count only inside a %s; a zero byte closes it.
            if (str_q) begin
                if (ch == CH_NUL) begin
                    str_q = 1'b0;
                end else begin
                    put_char(ch);
                end
            end
        end else begin
            str_q = 1'b0;
            render_format(ch, P_ARG_BITS'(arg));
        end
        if (expected_text.size() > mark) begin
            tail = expected_text.pop_back();
            tail.last = 1'b1;
            expected_text.push_back(tail);
        end
    endfunction

    // Present one word, hold it until taken, then predict its text. valid is
    // left high so back-to-back words need no extra assignment.
    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [31:0] arg);
        int gap;
        gap = quiet ? 0 : pause_len();
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.opcode    <= op;
        item_bus.char_byte <= ch;
        item_bus.arg_value <= arg;
        do @(posedge clk); while (!item_bus.ready);
        render_item(op, ch, arg);
        if (op != OP_NONE) items_sent++;
    endtask

    // A conversion is a '%' word followed by the specifier word.
    task automatic send_spec(input logic [7:0] spec, input logic [31:0] arg);
        send_item(OP_FMT, CH_PCT, 32'($urandom()));
        send_item(OP_FMT, spec, arg);
    endtask

    // Drop valid and hold off until every predicted word has come out.
    task automatic wait_for_text();
        item_bus.valid <= 1'b0;
        do @(posedge clk); while (expected_text.size() != 0);
    endtask

    // Write buffer_capacity over APB once the block has gone quiet.
    task automatic set_capacity(input logic [15:0] cap);
        wait_for_text();
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= {16'd0, cap};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_q = cap;
        caps_used++;
    endtask

    // Plain text, '%%', and a zero character between '%' and its specifier.
    task automatic test_literal_text();
        send_item(OP_FMT, "A", '0);
        send_item(OP_FMT, 8'hff, '0);
        send_spec(CH_PCT, '1);
        send_item(OP_FMT, CH_PCT, '0);
        send_item(OP_FMT, CH_NUL, '0);
        send_item(OP_FMT, CH_D, '1);
    endtask

    // Every integer and character conversion at an edge of its argument range.
    task automatic test_conversions();
        send_spec(CH_D, 32'h8000_0000);
        send_spec(CH_U, '1);
        send_spec(CH_C, 32'h1234_56ff);
        send_spec(CH_X, '0);
        send_spec(CH_B, '1);
        send_item(OP_END, '0, '0);
    endtask

    // String arguments: closed by a zero byte, and left by a format word;
    // stray string bytes and the unused opcode do nothing.
    task automatic test_string_args();
        send_spec(CH_S, '0);
        send_item(OP_STR, 8'h80, '1);
        send_item(OP_STR, 8'h7f, '0);
        send_item(OP_STR, CH_NUL, '0);
        send_item(OP_STR, "q", '0);
        send_item(OP_NONE, 8'hff, '1);
        send_spec(CH_S, '1);
        send_item(OP_STR, "k", '0);
        send_item(OP_FMT, "Z", '0);
        send_item(OP_END, '0, '0);
    endtask

    // An unknown specifier sets the status and mutes the rest of the message.
    task automatic test_unknown_spec();
        send_spec("q", '1);
        send_item(OP_FMT, "A", '0);
        send_spec(CH_D, 32'd5);
        send_item(OP_END, '0, '0);
    endtask

    // A conversion cut short at capacity, a full buffer, and zero capacity.
    task automatic test_capacity_limits();
        set_capacity(16'd3);
        send_spec(CH_X, 32'h0000_1234);
        send_item(OP_FMT, "A", '0);
        send_item(OP_END, '0, '0);
        set_capacity(16'd0);
        send_item(OP_FMT, "A", '0);
        send_item(OP_END, '0, '0);
    endtask

    // One random piece of a message: literal, conversion, string argument or
    // noise.
    task automatic send_segment();
        logic [7:0] ch;
        logic [7:0] specs [6];
        int         r;
        int         n;
        specs = '{CH_D, CH_U, CH_C, CH_X, CH_B, CH_PCT};
        r = $urandom_range(0, 99);
        if (r < 30) begin
            do ch = 8'($urandom_range(1, 255)); while (ch == CH_PCT);
            send_item(OP_FMT, ch, 32'($urandom()));
        end else if (r < 65) begin
            send_spec(specs[$urandom_range(0, 5)], pick_arg());
        end else if (r < 80) begin
            send_spec(CH_S, 32'($urandom()));
            n = $urandom_range(0, 6);
            repeat (n) send_item(OP_STR, 8'($urandom_range(1, 255)), 32'($urandom()));
            // Leave some strings open so a format word has to close them.
            if ($urandom_range(0, 4) != 0) send_item(OP_STR, CH_NUL, 32'($urandom()));
        end else begin
            case ($urandom_range(0, 4))
                0: begin
                    do ch = 8'($urandom_range(1, 255));
                    while (ch inside {CH_PCT, CH_D, CH_U, CH_C, CH_S, CH_X, CH_B});
                    send_spec(ch, pick_arg());
                end
                1: send_item(OP_FMT, CH_NUL, 32'($urandom()));
                2: send_item(OP_STR, 8'($urandom()), 32'($urandom()));
                3: send_item(OP_NONE, 8'($urandom()), 32'($urandom()));
                default: send_item(2'($urandom_range(0, 3)), 8'($urandom()),
                                   32'($urandom()));
            endcase
        end
    endtask

    // Messages with random content and noise, ended by an end word; hold
    // off once part way through when asked.
    task automatic test_random_messages(input int n_items, input bit pause_midway);
        int start;
        bit paused;
        start  = items_sent;
        paused = 1'b0;
        while (items_sent - start < n_items) begin
            send_segment();
            if ($urandom_range(0, 7) == 0) send_item(OP_END, '0, 32'($urandom()));
            if (pause_midway && !paused && items_sent - start >= n_items / 2) begin
                wait_for_text();
                paused = 1'b1;
            end
        end
        send_item(OP_END, '0, '0);
    endtask

    // Receiver: stall at random, never while quiet.
    initial begin : text_sink
        int n;
        text_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            n = quiet ? 0 : pause_len();
            if (n > 0) begin
                text_bus.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            text_bus.ready <= 1'b1;
        end
    end

    // Compare each accepted text word with the oldest prediction.
    always @(posedge clk) begin : check_text
        t_text_word want;
        if (rst_n && text_bus.valid && text_bus.ready) begin
            words_checked++;
            if (expected_text.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word byte=%02h last=%0b status=%0b", $time,
                         text_bus.out_byte, text_bus.last, text_bus.status);
            end else begin
                want = expected_text.pop_front();
                if (want.out_byte !== text_bus.out_byte || want.last !== text_bus.last ||
                    want.status !== text_bus.status) begin
                    mismatches++;
                    $display("%0t: expected %02h/%0b/%0b got %02h/%0b/%0b (byte/last/status)",
                             $time, want.out_byte, want.last, want.status,
                             text_bus.out_byte, text_bus.last, text_bus.status);
                end
            end
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((item_bus.valid && item_bus.ready) || (text_bus.valid && text_bus.ready) ||
                (psel && penable)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        // Drive every input to a known value before the first edge.
        rst_n              <= 1'b0;
        item_bus.valid     <= 1'b0;
        item_bus.opcode    <= OP_FMT;
        item_bus.char_byte <= '0;
        item_bus.arg_value <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        cap_q         = P_CAP_RESET;
        written_q     = '0;
        pct_q         = 1'b0;
        str_q         = 1'b0;
        bad_q         = 1'b0;
        mismatches    = 0;
        words_checked = 0;
        items_sent    = 0;
        caps_used     = 0;
        quiet         = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed checks start at the reset capacity; the last one changes it.
        test_literal_text();
        test_conversions();
        test_string_args();
        test_unknown_spec();
        test_capacity_limits();

        // Random messages across capacity settings, one phase at full rate.
        set_capacity(P_CAP_RESET);
        test_random_messages(50, 1'b1);
        set_capacity(16'hffff);
        quiet = 1'b1;
        test_random_messages(50, 1'b0);
        quiet = 1'b0;
        set_capacity(16'd1);
        test_random_messages(25, 1'b0);
        set_capacity(16'($urandom_range(4, 40)));
        test_random_messages(30, 1'b1);

        wait_for_text();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d input words under %0d capacity writes; %0d text words compared.",
                 items_sent, caps_used, words_checked);
        $display("Covered literals, all conversions, strings, bad specifiers and buffer limits.");
        if (mismatches == 0 && expected_text.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* format_string_integer_formatter.f */
rtl/fsif_pkg.sv
rtl/fsif_if.sv
rtl/fsif_cfg.sv
rtl/fsif_conv.sv
rtl/format_string_integer_formatter.sv
bench/tb_format_string_integer_formatter.sv
